@@ hdl/wfca_pkg.sv @@
// Package for the worst-fit cell allocator: field widths, status and request codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package wfca_pkg;

   localparam int OWNER_W    = 8;
   localparam int SIZE_W     = 11;
   localparam int CELL_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic REQ_ALLOCATE = 1'b0;
   localparam logic REQ_RELEASE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_NO_ROOM   = 2'd1,
      STATUS_RELEASED  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic eval;
      logic fill;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic release_op;
      logic fits;
      logic fill_last;
   } dp_status_type;

endpackage

@@ hdl/wfca_ctrl.sv @@
// Controller state machine of the worst-fit cell allocator.
// Sequences clear, scan, evaluate and fill; depends on wfca_pkg.
module wfca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   out_free,
   input  wfca_pkg::dp_status_type dp_status,
   output wfca_pkg::cmd_type      cmd,
   output logic                   req_tready,
   output logic                   out_load
);

   wfca_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wfca_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         wfca_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (dp_status.addr_last) state_in = wfca_pkg::ST_IDLE;
         end
         wfca_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = wfca_pkg::ST_SCAN;
            end
         end
         wfca_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (dp_status.addr_last) state_in = wfca_pkg::ST_DRAIN;
         end
         wfca_pkg::ST_DRAIN: begin
            state_in = wfca_pkg::ST_EVAL;
         end
         wfca_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            if (!dp_status.release_op && dp_status.fits) begin
               state_in = wfca_pkg::ST_FILL;
            end else begin
               state_in = wfca_pkg::ST_DONE;
            end
         end
         wfca_pkg::ST_FILL: begin
            cmd.fill = 1'b1;
            if (dp_status.fill_last) state_in = wfca_pkg::ST_DONE;
         end
         wfca_pkg::ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = wfca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfca_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

@@ hdl/wfca_dp.sv @@
// Datapath of the worst-fit cell allocator: owner map memory, scan counters,
// run tracking, fill sequencing and result registers. Depends on wfca_pkg.
module wfca_dp #(
   parameter int CELLS      = 1024,
   parameter int OWNER_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wfca_pkg::cmd_type               cmd,
   input  logic                            req_type,
   input  logic [wfca_pkg::OWNER_W-1:0]    owner_id,
   input  logic [wfca_pkg::SIZE_W-1:0]     alloc_size,
   output wfca_pkg::dp_status_type         dp_status,
   output logic [wfca_pkg::STATUS_W-1:0]   res_status,
   output logic [wfca_pkg::CELL_W-1:0]     res_start,
   output logic [wfca_pkg::CELL_W-1:0]     res_end
);

   localparam int AW   = $clog2(CELLS);
   localparam int LW   = $clog2(CELLS + 1);
   localparam int CW   = OWNER_BITS + 1;
   localparam int CMPW = (LW > wfca_pkg::SIZE_W) ? LW : wfca_pkg::SIZE_W;

   logic [CW-1:0] cell_mem_ff [CELLS];

   logic [AW-1:0]                   addr_ff, addr_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [CW-1:0]                   rd_data_ff;
   logic [AW-1:0]                   rd_addr_ff;
   logic                            kind_ff, kind_in;
   logic [OWNER_BITS-1:0]           owner_ff, owner_in;
   logic [wfca_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [LW-1:0]                   run_len_ff, run_len_in;
   logic [AW-1:0]                   run_start_ff, run_start_in;
   logic [LW-1:0]                   best_len_ff, best_len_in;
   logic [AW-1:0]                   best_start_ff, best_start_in;
   logic [AW-1:0]                   fill_addr_ff, fill_addr_in;
   logic [LW-1:0]                   fill_left_ff, fill_left_in;
   logic [wfca_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [wfca_pkg::CELL_W-1:0]     res_start_ff, res_start_in;
   logic [wfca_pkg::CELL_W-1:0]     res_end_ff, res_end_in;

   logic          addr_last;
   logic          cell_used;
   logic          owner_hit;
   logic          take_run;
   logic [LW-1:0] fin_len;
   logic [AW-1:0] fin_start;
   logic          fits;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [CW-1:0] mem_wd;

   assign addr_last = (addr_ff == AW'(CELLS - 1));
   assign cell_used = rd_data_ff[OWNER_BITS];
   assign owner_hit = (rd_data_ff[OWNER_BITS-1:0] == owner_ff);
   assign take_run  = (run_len_ff > best_len_ff);
   assign fin_len   = take_run ? run_len_ff : best_len_ff;
   assign fin_start = take_run ? run_start_ff : best_start_ff;
   assign fits      = (size_ff != '0) && (CMPW'(fin_len) >= CMPW'(size_ff));

   assign dp_status.addr_last  = addr_last;
   assign dp_status.release_op = (kind_ff == wfca_pkg::REQ_RELEASE);
   assign dp_status.fits       = fits;
   assign dp_status.fill_last  = (fill_left_ff == LW'(1));

   assign res_status = res_status_ff;
   assign res_start  = res_start_ff;
   assign res_end    = res_end_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = rd_addr_ff;
      mem_wd = '0;
      if (cmd.clear) begin
         mem_we = 1'b1;
         mem_wa = addr_ff;
      end else if (cmd.fill) begin
         mem_we = 1'b1;
         mem_wa = fill_addr_ff;
         mem_wd = {1'b1, owner_ff};
      end else if (rd_valid_ff && (kind_ff == wfca_pkg::REQ_RELEASE) && cell_used
                   && owner_hit) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem_ff[mem_wa] <= mem_wd;
      rd_data_ff <= cell_mem_ff[addr_ff];
      rd_addr_ff <= addr_ff;
   end

   always_comb begin
      addr_in       = addr_ff;
      rd_valid_in   = cmd.scan;
      kind_in       = kind_ff;
      owner_in      = owner_ff;
      size_in       = size_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      fill_addr_in  = fill_addr_ff;
      fill_left_in  = fill_left_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_end_in    = res_end_ff;

      if (cmd.clear || cmd.scan) begin
         addr_in = addr_last ? '0 : AW'(addr_ff + 1'b1);
      end

      if (cmd.load) begin
         addr_in       = '0;
         kind_in       = req_type;
         owner_in      = OWNER_BITS'(owner_id);
         size_in       = alloc_size;
         run_len_in    = '0;
         run_start_in  = '0;
         best_len_in   = '0;
         best_start_in = '0;
         res_status_in = (req_type == wfca_pkg::REQ_RELEASE) ?
                         wfca_pkg::STATUS_RELEASED : wfca_pkg::STATUS_NO_ROOM;
         res_start_in  = '0;
         res_end_in    = '0;
      end

      if (rd_valid_ff) begin
         if (!cell_used) begin
            if (run_len_ff == '0) run_start_in = rd_addr_ff;
            run_len_in = LW'(run_len_ff + 1'b1);
         end else begin
            if (take_run) begin
               best_len_in   = run_len_ff;
               best_start_in = run_start_ff;
            end
            run_len_in = '0;
         end
      end

      if (cmd.eval) begin
         best_len_in   = fin_len;
         best_start_in = fin_start;
         fill_addr_in  = fin_start;
         fill_left_in  = LW'(size_ff);
         if ((kind_ff == wfca_pkg::REQ_ALLOCATE) && fits) begin
            res_status_in = wfca_pkg::STATUS_ALLOCATED;
            res_start_in  = wfca_pkg::CELL_W'(fin_start);
            res_end_in    = wfca_pkg::CELL_W'(wfca_pkg::CELL_W'(fin_start)
                            + wfca_pkg::CELL_W'(size_ff) - wfca_pkg::CELL_W'(1));
         end
      end

      if (cmd.fill) begin
         fill_addr_in = AW'(fill_addr_ff + 1'b1);
         fill_left_in = LW'(fill_left_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      owner_ff      <= owner_in;
      size_ff       <= size_in;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      fill_addr_ff  <= fill_addr_in;
      fill_left_ff  <= fill_left_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
   end

endmodule

@@ hdl/worst_fit_cell_allocator.sv @@
// Worst-fit cell allocator, top level: controller, datapath and response register.
// A request is accepted, the owner map is scanned, the result is evaluated and, on a
// granted allocate, the cells are filled before the response beat is registered. One
// request at a time: a new request is taken only after the response of the last one is
// loaded into the response register. After reset a clearing pass frees every cell;
// req_tready stays low until it ends. Depends on wfca_pkg.
module worst_fit_cell_allocator #(
   parameter int CELLS      = 1024,
   parameter int OWNER_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wfca_pkg::REQ_DATA_W-1:0]   req_tdata,  // owner_id[7:0], alloc_size[18:8]
   input  logic                              req_tuser,  // req_type[0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wfca_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // start_cell[9:0], end_cell[19:10]
   output logic [wfca_pkg::STATUS_W-1:0]     rsp_tuser   // status[1:0]
);

   wfca_pkg::cmd_type        cmd;
   wfca_pkg::dp_status_type  dp_status;
   logic                     out_free;
   logic                     out_load;
   logic [wfca_pkg::STATUS_W-1:0] res_status;
   logic [wfca_pkg::CELL_W-1:0]   res_start;
   logic [wfca_pkg::CELL_W-1:0]   res_end;

   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [wfca_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [wfca_pkg::STATUS_W-1:0]   rsp_tuser_ff, rsp_tuser_in;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   wfca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .dp_status  (dp_status),
      .cmd        (cmd),
      .req_tready (req_tready),
      .out_load   (out_load)
   );

   wfca_dp #(
      .CELLS      (CELLS),
      .OWNER_BITS (OWNER_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_type   (req_tuser),
      .owner_id   (req_tdata[wfca_pkg::OWNER_W-1:0]),
      .alloc_size (req_tdata[wfca_pkg::OWNER_W+wfca_pkg::SIZE_W-1:wfca_pkg::OWNER_W]),
      .dp_status  (dp_status),
      .res_status (res_status),
      .res_start  (res_start),
      .res_end    (res_end)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{(wfca_pkg::RSP_DATA_W - 2*wfca_pkg::CELL_W){1'b0}},
                          res_end, res_start};
         rsp_tuser_in  = res_status;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

@@ hdl/wfca_checker.sv @@
// Port-level assertions for the worst-fit cell allocator and the bind that attaches them.
// Depends on wfca_pkg and worst_fit_cell_allocator.
module wfca_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [wfca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [wfca_pkg::STATUS_W-1:0]     rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == wfca_pkg::STATUS_ALLOCATED)
                  || (rsp_tuser == wfca_pkg::STATUS_NO_ROOM)
                  || (rsp_tuser == wfca_pkg::STATUS_RELEASED))
      else $error("undefined response status");

   a_zero_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != wfca_pkg::STATUS_ALLOCATED) |-> (rsp_tdata == '0))
      else $error("cell range not zero on failed allocation or release");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous request still in work");

endmodule

bind worst_fit_cell_allocator wfca_checker u_wfca_checker (.*);
